>>> rtl/sem_pkg.sv
// shared constants and types for the sobel edge magnitude block
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WREG_W  = 11;
    localparam int HREG_W  = 13;
    localparam int CFG_W   = 13;
    localparam int GRAD_W  = 11;
    localparam int MAG_W   = 11;
    localparam int SQ_W    = 21;
    localparam int LINE_W  = 2 * PIX_W;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // handshake between the sequencer and the root unit
    typedef struct packed {
        logic start;
    } root_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

>>> rtl/sem_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sem_sqrt.sv
// iterative integer floor square root, two operand bits per cycle
`timescale 1ns / 1ps

module sem_sqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sem_pkg::root_ctl_t     ctl,
    input  logic [sem_pkg::SQ_W-1:0] operand,
    output sem_pkg::root_stat_t    stat,
    output logic [sem_pkg::MAG_W-1:0] root
);
    import sem_pkg::*;

    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W:0]   res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W:0]   trial;

    assign trial = res_reg + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                rem_reg  <= operand;
                res_reg  <= '0;
                bit_reg  <= {1'b1, {(SQ_W-1){1'b0}}};
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg <= rem_reg - trial[SQ_W-1:0];
                    res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                // the last step works on the ones bit
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[MAG_W-1:0];

endmodule

>>> rtl/sobel_edge_magnitude_unit.sv
// sobel edge magnitude top level: line store, window, sequencer and output register
`timescale 1ns / 1ps

// Streaming 3x3 Sobel gradient block. Pixels enter in raster order on the s_ channel; the
// two rows above are kept in one 16-bit wide line memory (one entry per column, registered
// read), and a pixel at column x >= 2 of row y >= 2 gives one result on the m_ channel for
// position (x-1, y-1): grad_x, grad_y and the floor square root of their square sum.
// A pixel that gives no result is accepted, then its line memory entry is read and written
// back; one that gives a result then has its gradients squared and waits on the iterative root
// unit, which resolves two bits of the square sum per cycle over 11 steps. The result sits
// in an output register, so the next pixel is taken while it waits; a further result holds
// the block until that register is free. Sizes are written on the cfg port while idle;
// width saturates to [3, 1024] and height to [3, 4096]. The line memory needs no clearing
// after reset: within a frame of fixed width every entry that feeds a result was written
// first.
module sobel_edge_magnitude_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sem_pkg::PIX_W-1:0]     s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sem_pkg::MAG_W-1:0]     m_magnitude,
    output logic signed [sem_pkg::GRAD_W-1:0] m_grad_x,
    output logic signed [sem_pkg::GRAD_W-1:0] m_grad_y,
    output logic [sem_pkg::COL_W-1:0]     m_out_col,
    output logic [sem_pkg::ROW_W-1:0]     m_out_row,
    output logic                          m_frame_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  sem_pkg::reg_index_t           cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data
);
    import sem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAD,
        S_SQUARE,
        S_START,
        S_ROOT,
        S_OUT
    } state_t;

    typedef logic signed [GRAD_W:0] wide_t;

    state_t state_reg;

    logic [WREG_W-1:0] image_width_reg;
    logic [HREG_W-1:0] image_height_reg;
    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;

    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [PIX_W-1:0] px_reg;

    // column x-2 and column x-1 of the window, top to bottom
    logic [PIX_W-1:0] top0_reg, mid0_reg, bot0_reg;
    logic [PIX_W-1:0] top1_reg, mid1_reg, bot1_reg;

    logic [LINE_W-1:0] line_rdata;
    logic [PIX_W-1:0]  top_px, mid_px;
    logic              line_we;

    wide_t gx, gy;
    logic  emit;
    logic  is_last;
    logic [WREG_W-1:0] col_inc;
    logic [HREG_W-1:0] row_inc;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [COL_W-1:0]         ocol_reg;
    logic [ROW_W-1:0]         orow_reg;
    logic                     last_reg;
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SQ_W-1:0]          gx2_reg, gy2_reg;

    root_ctl_t  root_ctl;
    root_stat_t root_stat;
    logic [MAG_W-1:0] root;

    logic                     m_valid_reg;
    logic [MAG_W-1:0]         m_mag_reg;
    logic signed [GRAD_W-1:0] m_gx_reg, m_gy_reg;
    logic [COL_W-1:0]         m_col_reg;
    logic [ROW_W-1:0]         m_row_reg;
    logic                     m_last_reg;

    always_comb begin
        if (image_width_reg < WREG_W'(3)) begin
            w_eff = WREG_W'(3);
        end else if (image_width_reg > WREG_W'(MAX_WIDTH)) begin
            w_eff = WREG_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg < HREG_W'(3)) begin
            h_eff = HREG_W'(3);
        end else if (image_height_reg > HREG_W'(MAX_HEIGHT)) begin
            h_eff = HREG_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign top_px  = line_rdata[LINE_W-1:PIX_W];
    assign mid_px  = line_rdata[PIX_W-1:0];
    assign line_we = (state_reg == S_GRAD);

    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (col_count_reg),
        .wdata ({mid_px, px_reg}),
        .raddr (col_count_reg),
        .rdata (line_rdata)
    );

    always_comb begin
        gx = (wide_t'({1'b0, top_px}) - wide_t'({1'b0, top0_reg}))
           + ((wide_t'({1'b0, mid_px}) - wide_t'({1'b0, mid0_reg})) <<< 1)
           + (wide_t'({1'b0, px_reg}) - wide_t'({1'b0, bot0_reg}));
        gy = (wide_t'({1'b0, bot0_reg}) + (wide_t'({1'b0, bot1_reg}) <<< 1)
              + wide_t'({1'b0, px_reg}))
           - (wide_t'({1'b0, top0_reg}) + (wide_t'({1'b0, top1_reg}) <<< 1)
              + wide_t'({1'b0, top_px}));
    end

    assign col_inc = WREG_W'(col_count_reg) + WREG_W'(1);
    assign row_inc = HREG_W'(row_count_reg) + HREG_W'(1);
    assign emit    = (col_count_reg >= COL_W'(2)) && (row_count_reg >= ROW_W'(2))
                  && (WREG_W'(col_count_reg) < w_eff) && (HREG_W'(row_count_reg) < h_eff);
    assign is_last = (col_inc == w_eff) && (row_inc == h_eff);

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    assign root_ctl.start = (state_reg == S_START);

    sem_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (root_ctl),
        .operand (gx2_reg + gy2_reg),
        .stat    (root_stat),
        .root    (root)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WREG_W'(640);
            image_height_reg <= HREG_W'(480);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WREG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HREG_W-1:0];
            endcase
        end
    end

    // sequencer, window, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            top0_reg      <= '0;
            mid0_reg      <= '0;
            bot0_reg      <= '0;
            top1_reg      <= '0;
            mid1_reg      <= '0;
            bot1_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // in S_OUT the output register is handled by the state itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        px_reg    <= s_pixel;
                        state_reg <= S_GRAD;
                    end
                end
                S_GRAD: begin
                    gx_reg   <= gx[GRAD_W-1:0];
                    gy_reg   <= gy[GRAD_W-1:0];
                    ocol_reg <= col_count_reg - COL_W'(1);
                    orow_reg <= row_count_reg - ROW_W'(1);
                    last_reg <= is_last;
                    top0_reg <= top1_reg;
                    mid0_reg <= mid1_reg;
                    bot0_reg <= bot1_reg;
                    top1_reg <= top_px;
                    mid1_reg <= mid_px;
                    bot1_reg <= px_reg;
                    if (col_inc >= w_eff) begin
                        col_count_reg <= '0;
                        row_count_reg <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
                    end else begin
                        col_count_reg <= col_inc[COL_W-1:0];
                    end
                    state_reg <= emit ? S_SQUARE : S_IDLE;
                end
                S_SQUARE: begin
                    gx2_reg   <= gx_sq[SQ_W-1:0];
                    gy2_reg   <= gy_sq[SQ_W-1:0];
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_stat.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_mag_reg   <= root;
                        m_gx_reg    <= gx_reg;
                        m_gy_reg    <= gy_reg;
                        m_col_reg   <= ocol_reg;
                        m_row_reg   <= orow_reg;
                        m_last_reg  <= last_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_magnitude  = m_mag_reg;
    assign m_grad_x     = m_gx_reg;
    assign m_grad_y     = m_gy_reg;
    assign m_out_col    = m_col_reg;
    assign m_out_row    = m_row_reg;
    assign m_frame_last = m_last_reg;

endmodule

>>> rtl/sem_checker.sv
// port level checks for the sobel edge magnitude block, bound to the top level
`timescale 1ns / 1ps

module sem_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sem_pkg::MAG_W-1:0]     m_magnitude,
    input logic signed [sem_pkg::GRAD_W-1:0] m_grad_x,
    input logic signed [sem_pkg::GRAD_W-1:0] m_grad_y,
    input logic [sem_pkg::COL_W-1:0]     m_out_col,
    input logic [sem_pkg::ROW_W-1:0]     m_out_row,
    input logic                          m_frame_last
);
    import sem_pkg::*;

    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [2*GRAD_W:0]          sq_sum;
    logic [2*MAG_W+1:0]         mag_sq, mag1_sq;

    assign gx_sq   = m_grad_x * m_grad_x;
    assign gy_sq   = m_grad_y * m_grad_y;
    assign sq_sum  = {1'b0, gx_sq} + {1'b0, gy_sq};
    assign mag_sq  = (2*MAG_W+2)'(m_magnitude) * (2*MAG_W+2)'(m_magnitude);
    assign mag1_sq = ((2*MAG_W+2)'(m_magnitude) + 1'b1) * ((2*MAG_W+2)'(m_magnitude) + 1'b1);

    // nothing is shown in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude) && $stable(m_grad_x)
            && $stable(m_grad_y) && $stable(m_out_col) && $stable(m_out_row)
            && $stable(m_frame_last))
        else $error("stalled result changed");

    // magnitude is the floor root of the gradient square sum
    a_root_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (mag_sq <= (2*MAG_W+2)'(sq_sum)) && ((2*MAG_W+2)'(sq_sum) < mag1_sq))
        else $error("magnitude is not the floor root of the gradients");

    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_col != '0) && (m_out_row != '0))
        else $error("result on a border position");

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (.*);
